// ===== rtl/core/ladrc_pkg.sv =====
// shared types, constants and the tick sequence of the disturbance rejection controller
`timescale 1ns / 1ps
package ladrc_pkg;

    typedef logic signed [47:0] q_t;

    localparam q_t Q_MAX       = 48'sh7FFF_FFFF_FFFF;
    localparam q_t Q_MIN       = 48'sh8000_0000_0000;
    localparam q_t Q_ONE       = 48'sd16777216;
    localparam q_t Q_TWO       = 48'sd33554432;
    localparam q_t Q_THREE     = 48'sd50331648;
    localparam q_t Q_FIVE      = 48'sd83886080;
    localparam q_t DRIVE_LIMIT = 48'sd268435456000;
    localparam q_t DRIVE_FLOOR = -48'sd268435456000;

    localparam int DRIVE_W = 39;
    localparam int PC_W    = 6;
    localparam logic [PC_W-1:0] PROG_LAST = 6'd52;

    localparam logic [2:0] CFG_STEP  = 3'd0;
    localparam logic [2:0] CFG_SPEED = 3'd1;
    localparam logic [2:0] CFG_KP    = 3'd2;
    localparam logic [2:0] CFG_KD    = 3'd3;
    localparam logic [2:0] CFG_B0    = 3'd4;
    localparam logic [2:0] CFG_BETA  = 3'd5;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_NEG, OP_SCL3, OP_HALF, OP_CLAMP, OP_MUL, OP_DIV
    } op_t;

    typedef enum logic [4:0] {
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
        S_REFP, S_REFR, S_EP, S_ER, S_ED, S_LD,
        S_TGT, S_MEAS,
        S_H, S_R, S_KP, S_KD, S_B0, S_BETA,
        S_ONE, S_TWO, S_THREE, S_FIVE
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t dst;
        src_t a;
        src_t b;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic issue;
        uop_t uop;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

    function automatic logic [47:0] mag(input q_t a);
        mag = a[47] ? 48'(-a) : 48'(a);
    endfunction

    function automatic q_t sat_mag(input logic neg, input logic [50:0] m);
        q_t v;
        v = q_t'({1'b0, m[46:0]});
        if (m >= 51'h0_8000_0000_0000) begin
            sat_mag = neg ? Q_MIN : Q_MAX;
        end else begin
            sat_mag = neg ? -v : v;
        end
    endfunction

    function automatic uop_t u(input op_t o, input src_t d, input src_t x, input src_t y);
        u = '{op: o, dst: d, a: x, b: y};
    endfunction

    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        unique case (pc)
            // tracking differentiator
            6'd0:  prog = u(OP_MUL,  S_T0,   S_R,    S_R);
            6'd1:  prog = u(OP_SUB,  S_T1,   S_REFP, S_TGT);
            6'd2:  prog = u(OP_MUL,  S_T0,   S_T0,   S_T1);
            6'd3:  prog = u(OP_NEG,  S_T0,   S_T0,   S_ONE);
            6'd4:  prog = u(OP_ADD,  S_T1,   S_R,    S_R);
            6'd5:  prog = u(OP_MUL,  S_T1,   S_T1,   S_REFR);
            6'd6:  prog = u(OP_SUB,  S_T0,   S_T0,   S_T1);
            6'd7:  prog = u(OP_MUL,  S_T1,   S_REFR, S_H);
            6'd8:  prog = u(OP_ADD,  S_REFP, S_REFP, S_T1);
            6'd9:  prog = u(OP_MUL,  S_T0,   S_T0,   S_H);
            6'd10: prog = u(OP_ADD,  S_REFR, S_REFR, S_T0);
            // observer
            6'd11: prog = u(OP_MUL,  S_T0,   S_H,    S_H);
            6'd12: prog = u(OP_MUL,  S_T1,   S_B0,   S_H);
            6'd13: prog = u(OP_SUB,  S_T2,   S_BETA, S_ONE);
            6'd14: prog = u(OP_MUL,  S_T3,   S_T2,   S_T2);
            6'd15: prog = u(OP_SUB,  S_T4,   S_MEAS, S_EP);
            6'd16: prog = u(OP_MUL,  S_T5,   S_H,    S_ER);
            6'd17: prog = u(OP_MUL,  S_T6,   S_T0,   S_ED);
            6'd18: prog = u(OP_HALF, S_T6,   S_T6,   S_ONE);
            6'd19: prog = u(OP_ADD,  S_T5,   S_T5,   S_T6);
            6'd20: prog = u(OP_SCL3, S_T6,   S_BETA, S_ONE);
            6'd21: prog = u(OP_SUB,  S_T6,   S_T6,   S_THREE);
            6'd22: prog = u(OP_MUL,  S_T6,   S_MEAS, S_T6);
            6'd23: prog = u(OP_SUB,  S_T5,   S_T5,   S_T6);
            6'd24: prog = u(OP_SCL3, S_T6,   S_BETA, S_ONE);
            6'd25: prog = u(OP_SUB,  S_T6,   S_T6,   S_TWO);
            6'd26: prog = u(OP_MUL,  S_T6,   S_EP,   S_T6);
            6'd27: prog = u(OP_ADD,  S_T5,   S_T5,   S_T6);
            6'd28: prog = u(OP_MUL,  S_T6,   S_T1,   S_T1);
            6'd29: prog = u(OP_MUL,  S_T6,   S_T6,   S_LD);
            6'd30: prog = u(OP_HALF, S_T6,   S_T6,   S_ONE);
            6'd31: prog = u(OP_ADD,  S_EP,   S_T5,   S_T6);
            6'd32: prog = u(OP_ADD,  S_T6,   S_BETA, S_FIVE);
            6'd33: prog = u(OP_MUL,  S_T6,   S_T3,   S_T6);
            6'd34: prog = u(OP_MUL,  S_T7,   S_H,    S_ED);
            6'd35: prog = u(OP_ADD,  S_T7,   S_ER,   S_T7);
            6'd36: prog = u(OP_MUL,  S_T1,   S_T1,   S_LD);
            6'd37: prog = u(OP_ADD,  S_T7,   S_T7,   S_T1);
            6'd38: prog = u(OP_MUL,  S_T6,   S_T4,   S_T6);
            6'd39: prog = u(OP_ADD,  S_T1,   S_H,    S_H);
            6'd40: prog = u(OP_DIV,  S_T6,   S_T6,   S_T1);
            6'd41: prog = u(OP_ADD,  S_ER,   S_T7,   S_T6);
            6'd42: prog = u(OP_MUL,  S_T3,   S_T3,   S_T2);
            6'd43: prog = u(OP_MUL,  S_T3,   S_T4,   S_T3);
            6'd44: prog = u(OP_DIV,  S_T3,   S_T3,   S_T0);
            6'd45: prog = u(OP_SUB,  S_ED,   S_ED,   S_T3);
            // feedback law
            6'd46: prog = u(OP_SUB,  S_T0,   S_REFP, S_MEAS);
            6'd47: prog = u(OP_MUL,  S_T0,   S_KP,   S_T0);
            6'd48: prog = u(OP_MUL,  S_T1,   S_KD,   S_ER);
            6'd49: prog = u(OP_SUB,  S_T0,   S_T0,   S_T1);
            6'd50: prog = u(OP_SUB,  S_T0,   S_T0,   S_ED);
            6'd51: prog = u(OP_DIV,  S_T0,   S_T0,   S_B0);
            default: prog = u(OP_CLAMP, S_LD, S_T0,   S_ONE);
        endcase
    endfunction

endpackage

// ===== rtl/core/ladrc_mul.sv =====
// multi-cycle saturating fixed point multiplier built on one 24x24 multiplier
`timescale 1ns / 1ps
module ladrc_mul (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  ladrc_pkg::q_t  a,
    input  ladrc_pkg::q_t  b,
    output logic           done,
    output ladrc_pkg::q_t  res
);
    import ladrc_pkg::*;

    logic        busy_reg;
    logic [2:0]  step_reg;
    logic [23:0] ah_reg, al_reg, bh_reg, bl_reg;
    logic        neg_reg;
    logic [47:0] p_reg;
    logic [50:0] acc_reg;
    logic        ovf_reg;
    logic [23:0] x, y;
    logic [47:0] ma, mb;

    assign ma = mag(a);
    assign mb = mag(b);

    // partial product order: low*low, high*low, low*high, high*high
    always_comb begin
        unique case (step_reg)
            3'd0:    begin x = al_reg; y = bl_reg; end
            3'd1:    begin x = ah_reg; y = bl_reg; end
            3'd2:    begin x = al_reg; y = bh_reg; end
            default: begin x = ah_reg; y = bh_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= 3'd0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd5) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ah_reg  <= ma[47:24];
            al_reg  <= ma[23:0];
            bh_reg  <= mb[47:24];
            bl_reg  <= mb[23:0];
            neg_reg <= a[47] ^ b[47];
        end else if (busy_reg) begin
            p_reg <= x * y;
            unique case (step_reg)
                3'd1:    acc_reg <= 51'((p_reg + 48'h80_0000) >> 24);
                3'd2:    acc_reg <= acc_reg + 51'(p_reg);
                3'd3:    acc_reg <= acc_reg + 51'(p_reg);
                3'd4: begin
                    ovf_reg <= |p_reg[47:23];
                    acc_reg <= acc_reg + 51'({p_reg[22:0], 24'd0});
                end
                default: ;
            endcase
        end
    end

    assign done = busy_reg && (step_reg == 3'd5);
    assign res  = ovf_reg ? (neg_reg ? Q_MIN : Q_MAX) : sat_mag(neg_reg, acc_reg);

endmodule

// ===== rtl/core/ladrc_div.sv =====
// radix-2 restoring fixed point divider with rounding and saturation
`timescale 1ns / 1ps
module ladrc_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  ladrc_pkg::q_t  a,
    input  ladrc_pkg::q_t  d,
    output logic           done,
    output ladrc_pkg::q_t  res
);
    import ladrc_pkg::*;

    localparam logic [6:0] STEPS = 7'd73;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [72:0] dvd_reg;
    logic [47:0] md_reg;
    logic [48:0] rem_reg;
    logic [47:0] q_reg;
    logic        ovf_reg, neg_reg, zero_reg;
    q_t          zres_reg;
    logic [48:0] rem_sh;
    logic        qbit;
    logic [47:0] rnd;

    assign rem_sh = {rem_reg[47:0], dvd_reg[72]};
    assign qbit   = rem_sh >= {1'b0, md_reg};
    assign rnd    = {1'b0, q_reg[47:1]} + 48'(q_reg[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= (d == '0) ? STEPS : 7'd0;
        end else if (busy_reg) begin
            if (cnt_reg == STEPS) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= {mag(a), 25'd0};
            md_reg   <= mag(d);
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            neg_reg  <= a[47] ^ d[47];
            zero_reg <= (d == '0);
            zres_reg <= (a == '0) ? '0 : (a[47] ? Q_MIN : Q_MAX);
        end else if (busy_reg && cnt_reg != STEPS) begin
            rem_reg <= qbit ? (rem_sh - {1'b0, md_reg}) : rem_sh;
            q_reg   <= {q_reg[46:0], qbit};
            ovf_reg <= ovf_reg | q_reg[47];
            dvd_reg <= {dvd_reg[71:0], 1'b0};
        end
    end

    assign done = busy_reg && (cnt_reg == STEPS);

    always_comb begin
        priority if (zero_reg) res = zres_reg;
        else if (ovf_reg)      res = neg_reg ? Q_MIN : Q_MAX;
        else                   res = sat_mag(neg_reg, 51'(rnd));
    end

endmodule

// ===== rtl/core/ladrc_datapath.sv =====
// register set, configuration, saturating alu and shared arithmetic units
`timescale 1ns / 1ps
module ladrc_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [47:0]             cfg_wdata,
    input  ladrc_pkg::q_t           in_target,
    input  ladrc_pkg::q_t           in_measure,
    input  ladrc_pkg::ctrl_cmd_t    cmd,
    output ladrc_pkg::dp_status_t   status,
    output logic [38:0]             drive
);
    import ladrc_pkg::*;

    localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SUM_MIN = -50'sh0_8000_0000_0000;

    logic [46:0] step_reg, speed_reg, b0_reg;
    q_t          kp_reg, kd_reg;
    logic [24:0] beta_reg;

    q_t refp_reg, refr_reg, ep_reg, er_reg, ed_reg, ld_reg;
    q_t tgt_reg, meas_reg;
    q_t t_reg [8];
    src_t dst_reg;
    logic [38:0] drive_reg;

    q_t   opa, opb, alu_res, wr_val, mul_res, div_res;
    logic mul_start, div_start, mul_done, div_done, wr_en;
    src_t wr_dst;
    logic signed [49:0] ea, eb, sum;

    function automatic q_t rd(input src_t s);
        unique case (s)
            S_T0:    rd = t_reg[0];
            S_T1:    rd = t_reg[1];
            S_T2:    rd = t_reg[2];
            S_T3:    rd = t_reg[3];
            S_T4:    rd = t_reg[4];
            S_T5:    rd = t_reg[5];
            S_T6:    rd = t_reg[6];
            S_T7:    rd = t_reg[7];
            S_REFP:  rd = refp_reg;
            S_REFR:  rd = refr_reg;
            S_EP:    rd = ep_reg;
            S_ER:    rd = er_reg;
            S_ED:    rd = ed_reg;
            S_LD:    rd = ld_reg;
            S_TGT:   rd = tgt_reg;
            S_MEAS:  rd = meas_reg;
            S_H:     rd = q_t'({1'b0, step_reg});
            S_R:     rd = q_t'({1'b0, speed_reg});
            S_KP:    rd = kp_reg;
            S_KD:    rd = kd_reg;
            S_B0:    rd = q_t'({1'b0, b0_reg});
            S_BETA:  rd = q_t'({23'd0, beta_reg});
            S_ONE:   rd = Q_ONE;
            S_TWO:   rd = Q_TWO;
            S_THREE: rd = Q_THREE;
            S_FIVE:  rd = Q_FIVE;
            default: rd = '0;
        endcase
    endfunction

    assign opa = rd(cmd.uop.a);
    assign opb = rd(cmd.uop.b);
    assign ea  = 50'(opa);
    assign eb  = 50'(opb);

    always_comb begin
        sum     = '0;
        alu_res = '0;
        unique case (cmd.uop.op)
            OP_ADD:  sum = ea + eb;
            OP_SUB:  sum = ea - eb;
            OP_NEG:  sum = -ea;
            OP_SCL3: sum = ea + ea + ea;
            default: sum = '0;
        endcase
        unique case (cmd.uop.op)
            OP_HALF:  alu_res = sat_mag(opa[47], (51'(mag(opa)) + 51'd1) >> 1);
            OP_CLAMP: begin
                priority if (opa > DRIVE_LIMIT) alu_res = DRIVE_LIMIT;
                else if (opa < DRIVE_FLOOR)     alu_res = DRIVE_FLOOR;
                else                            alu_res = opa;
            end
            OP_MUL, OP_DIV: alu_res = '0;
            default: begin
                priority if (sum > SUM_MAX) alu_res = Q_MAX;
                else if (sum < SUM_MIN)     alu_res = Q_MIN;
                else                        alu_res = sum[47:0];
            end
        endcase
    end

    assign mul_start = cmd.issue && (cmd.uop.op == OP_MUL);
    assign div_start = cmd.issue && (cmd.uop.op == OP_DIV);

    ladrc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (opa),
        .b       (opb),
        .done    (mul_done),
        .res     (mul_res)
    );

    ladrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (opa),
        .d       (opb),
        .done    (div_done),
        .res     (div_res)
    );

    assign status.done = mul_done | div_done;

    // alu results land in the issue cycle, unit results when the unit finishes
    always_comb begin
        priority if (mul_done) begin
            wr_en = 1'b1; wr_dst = dst_reg; wr_val = mul_res;
        end else if (div_done) begin
            wr_en = 1'b1; wr_dst = dst_reg; wr_val = div_res;
        end else begin
            wr_en  = cmd.issue && !mul_start && !div_start;
            wr_dst = cmd.uop.dst;
            wr_val = alu_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) dst_reg <= cmd.uop.dst;
        if (cmd.capture) begin
            tgt_reg  <= in_target;
            meas_reg <= in_measure;
        end
        if (cmd.out_load) drive_reg <= ld_reg[38:0];
        if (wr_en) begin
            unique case (wr_dst)
                S_T0: t_reg[0] <= wr_val;
                S_T1: t_reg[1] <= wr_val;
                S_T2: t_reg[2] <= wr_val;
                S_T3: t_reg[3] <= wr_val;
                S_T4: t_reg[4] <= wr_val;
                S_T5: t_reg[5] <= wr_val;
                S_T6: t_reg[6] <= wr_val;
                S_T7: t_reg[7] <= wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 47'd16777;
            speed_reg <= '0;
            kp_reg    <= '0;
            kd_reg    <= '0;
            b0_reg    <= 47'd16777216;
            beta_reg  <= '0;
            refp_reg  <= '0;
            refr_reg  <= '0;
            ep_reg    <= '0;
            er_reg    <= '0;
            ed_reg    <= '0;
            ld_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_STEP:  step_reg  <= cfg_wdata[46:0];
                    CFG_SPEED: speed_reg <= cfg_wdata[46:0];
                    CFG_KP:    kp_reg    <= cfg_wdata;
                    CFG_KD:    kd_reg    <= cfg_wdata;
                    CFG_B0:    b0_reg    <= cfg_wdata[46:0];
                    CFG_BETA:  beta_reg  <= cfg_wdata[24:0];
                    default: ;
                endcase
            end
            if (wr_en) begin
                unique case (wr_dst)
                    S_REFP: refp_reg <= wr_val;
                    S_REFR: refr_reg <= wr_val;
                    S_EP:   ep_reg   <= wr_val;
                    S_ER:   er_reg   <= wr_val;
                    S_ED:   ed_reg   <= wr_val;
                    S_LD:   ld_reg   <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    assign drive = drive_reg;

endmodule

// ===== rtl/core/ladrc_ctrl.sv =====
// sequencer that steps the tick program and runs both stream handshakes
`timescale 1ns / 1ps
module ladrc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  ladrc_pkg::dp_status_t   status,
    output ladrc_pkg::ctrl_cmd_t    cmd
);
    import ladrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } st_t;

    st_t             st_reg, st_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            mv_reg, mv_next;
    uop_t            cur;
    logic            out_free;

    assign cur      = prog(pc_reg);
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        st_next      = st_reg;
        pc_next      = pc_reg;
        mv_next      = mv_reg && !m_tready;
        cmd.capture  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.uop      = cur;
        cmd.out_load = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    pc_next     = '0;
                    st_next     = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                priority if (cur.op == OP_MUL || cur.op == OP_DIV) begin
                    st_next = ST_WAIT;
                end else if (pc_reg == PROG_LAST) begin
                    st_next = ST_FINISH;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (status.done) begin
                    pc_next = pc_reg + 1'b1;
                    st_next = ST_ISSUE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            pc_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            pc_reg <= pc_next;
            mv_reg <= mv_next;
        end
    end

endmodule

// ===== rtl/core/linear_adrc_controller_core.sv =====
// top level of the linear disturbance rejection controller core
`timescale 1ns / 1ps
// one tick runs from input transaction to result transaction as 28 alu
// steps, 22 products on the shared 24x24 multiplier and 3 quotients on the
// bit-serial divider; one tick at a time, so no new input is taken until the
// result of the last tick is loaded, and the next input is taken while the
// previous result still waits on the output register
// synchronous active-low reset clears all controller and observer state
// and restores the register defaults
module linear_adrc_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // [47:0] target, [95:48] measure
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [38:0] drive, [39] zero
);
    import ladrc_pkg::*;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic [38:0] drive;

    // sequencer: walks the tick program, waits on the shared units
    ladrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: state, configuration and the arithmetic
    ladrc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_target  (s_tdata[47:0]),
        .in_measure (s_tdata[95:48]),
        .cmd        (cmd),
        .status     (status),
        .drive      (drive)
    );

    // drive padded to whole bytes
    assign m_tdata = {1'b0, drive};

endmodule
